>>> rtl/angle_unwrap_velocity_tracker_defines.svh
// ----------------------------------------------------------------------------
// Angle unwrap velocity tracker: assertion macros
// Shared property wrappers. They are clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ANGLE_UNWRAP_VELOCITY_TRACKER_DEFINES_SVH
`define ANGLE_UNWRAP_VELOCITY_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AUTV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AUTV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/autv_pkg.sv
// ----------------------------------------------------------------------------
// autv_pkg
// Widths, codes and helpers for the angle unwrap and velocity tracker.
// ----------------------------------------------------------------------------
package autv_pkg;

  localparam int ALPHA_W   = 17;
  localparam int GAIN_W    = 24;
  localparam int CFG_DATA_W = 24;
  localparam int CUSTOM_W  = 32;
  localparam int VEL_W     = 37;
  localparam int MUL_A_W   = VEL_W + 1;
  localparam int MUL_B_W   = GAIN_W + 1;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int FRAC_BITS = 16;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);
  localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(65536);

  // Command codes.
  localparam logic CMD_SAMPLE     = 1'b0;
  localparam logic CMD_SET_CUSTOM = 1'b1;

  // Register indexes.
  localparam logic CFG_FILTER_ALPHA  = 1'b0;
  localparam logic CFG_VELOCITY_GAIN = 1'b1;

  typedef struct packed {
    logic               go;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  // Clamp a wide signed value to the signed velocity range.
  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [MUL_P_W-1:0] v);
    logic signed [MUL_P_W-1:0] vmax;
    logic signed [MUL_P_W-1:0] vmin;
    vmax = MUL_P_W'({1'b0, {(VEL_W-1){1'b1}}});
    vmin = ~vmax;
    if (v > vmax) begin
      sat_vel = vmax[VEL_W-1:0];
    end else if (v < vmin) begin
      sat_vel = vmin[VEL_W-1:0];
    end else begin
      sat_vel = v[VEL_W-1:0];
    end
  endfunction

endpackage

>>> rtl/autv_unwrap.sv
// ----------------------------------------------------------------------------
// autv_unwrap
// Step between two absolute angles, folded into one half turn either way.
// ----------------------------------------------------------------------------
module autv_unwrap #(
  parameter int ANGLE_BITS = 12
) (
  input  logic [ANGLE_BITS-1:0]      angle_new,
  input  logic [ANGLE_BITS-1:0]      angle_old,
  output logic signed [ANGLE_BITS:0] delta
);

  localparam int WW = ANGLE_BITS + 2;
  localparam logic signed [WW-1:0] HALF = WW'(1) << (ANGLE_BITS - 1);
  localparam logic signed [WW-1:0] FULL = WW'(1) << ANGLE_BITS;

  logic signed [WW-1:0] raw_d;
  logic signed [WW-1:0] fold_d;

  always_comb begin
    raw_d = $signed({2'b00, angle_new}) - $signed({2'b00, angle_old});
    // A step of exactly half a turn is left alone.
    if (raw_d > HALF) begin
      fold_d = raw_d - FULL;
    end else if (raw_d < -HALF) begin
      fold_d = raw_d + FULL;
    end else begin
      fold_d = raw_d;
    end
    delta = fold_d[ANGLE_BITS:0];
  end

endmodule

>>> rtl/autv_mul.sv
// ----------------------------------------------------------------------------
// autv_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module autv_mul (
  input  logic                                  clk,
  input  autv_pkg::mul_req_t                    req,
  output logic signed [autv_pkg::MUL_P_W-1:0]   prod
);

  logic signed [autv_pkg::MUL_P_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (req.go) begin
      prod_r <= $signed(req.a) * $signed(req.b);
    end
  end

  assign prod = prod_r;

endmodule

>>> rtl/angle_unwrap_velocity_tracker.sv
// ----------------------------------------------------------------------------
// angle_unwrap_velocity_tracker
// Multi-turn angle, user offset and filtered velocity from absolute angle
// samples, with one shared multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake          Beat carries
//   in_      input      in_valid/in_stall  cmd, raw_angle, custom_value
//   out_     output     out_valid/out_stall angle, totals, velocities
//   cfg_     input      cfg_we             index, data
//
// A sample beat passes through MUL_VEL, VEL, MUL_FILT and FILT to DONE, where it
// loads the output register, and the next beat is taken only back in IDLE; a
// set command goes from IDLE straight to DONE. The multiplier is used twice per
// sample, once for the velocity and once for the filter step.
// Reset is synchronous on rst_n; the input is stalled while reset is low.
// A held output only delays the final load; the work before it goes on.
// ----------------------------------------------------------------------------
`include "angle_unwrap_velocity_tracker_defines.svh"

module angle_unwrap_velocity_tracker #(
  parameter int ANGLE_BITS = 12,
  parameter int TOTAL_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic [ANGLE_BITS-1:0]                 in_raw_angle,
  input  logic signed [autv_pkg::CUSTOM_W-1:0]  in_custom_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ANGLE_BITS-1:0]                 out_angle_now,
  output logic signed [TOTAL_BITS-1:0]          out_total_angle,
  output logic signed [TOTAL_BITS-1:0]          out_custom_total,
  output logic signed [autv_pkg::VEL_W-1:0]     out_velocity_raw,
  output logic signed [autv_pkg::VEL_W-1:0]     out_velocity_smooth,
  input  logic                                  cfg_we,
  input  logic                                  cfg_index,
  input  logic [autv_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int DW = ANGLE_BITS + 1;
  localparam int AW = (TOTAL_BITS > DW) ? TOTAL_BITS : DW;
  localparam int OW = (TOTAL_BITS > autv_pkg::CUSTOM_W) ? TOTAL_BITS : autv_pkg::CUSTOM_W;
  localparam int PW = autv_pkg::MUL_P_W;
  localparam int VW = autv_pkg::VEL_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_VEL,
    ST_VEL,
    ST_MUL_FILT,
    ST_FILT,
    ST_DONE
  } state_t;

  state_t st_r, st_nxt;

  logic [autv_pkg::ALPHA_W-1:0] alpha_r, alpha_nxt;
  logic [autv_pkg::GAIN_W-1:0]  gain_r, gain_nxt;

  logic [ANGLE_BITS-1:0]  last_r, last_nxt;
  logic [TOTAL_BITS-1:0]  acc_r, acc_nxt;
  logic [TOTAL_BITS-1:0]  off_r, off_nxt;
  logic signed [VW-1:0]   vel_r, vel_nxt;
  logic signed [VW-1:0]   filt_r, filt_nxt;
  logic signed [DW-1:0]   delta_r, delta_nxt;
  logic signed [VW:0]     diff_r, diff_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [ANGLE_BITS-1:0]  out_angle_r, out_angle_nxt;
  logic [TOTAL_BITS-1:0]  out_total_r, out_total_nxt;
  logic [TOTAL_BITS-1:0]  out_custom_r, out_custom_nxt;
  logic signed [VW-1:0]   out_vel_r, out_vel_nxt;
  logic signed [VW-1:0]   out_filt_r, out_filt_nxt;

  logic                          in_accept;
  logic signed [DW-1:0]          delta_w;
  autv_pkg::mul_req_t            mul_req;
  logic signed [PW-1:0]          prod;
  logic [autv_pkg::ALPHA_W-1:0]  alpha_sat;
  logic signed [VW-1:0]          vel_sat;
  logic [AW-1:0]                 acc_sum;
  logic signed [OW-1:0]          want_ext;
  logic [OW-1:0]                 off_diff;
  logic signed [PW-1:0]          filt_sum;

  autv_unwrap #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_unwrap (
    .angle_new (in_raw_angle),
    .angle_old (last_r),
    .delta     (delta_w)
  );

  autv_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  assign in_stall  = !rst_n || (st_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    st_r_defaults: begin
      st_nxt        = st_r;
      alpha_nxt     = alpha_r;
      gain_nxt      = gain_r;
      last_nxt      = last_r;
      acc_nxt       = acc_r;
      off_nxt       = off_r;
      vel_nxt       = vel_r;
      filt_nxt      = filt_r;
      delta_nxt     = delta_r;
      diff_nxt      = diff_r;
      out_valid_nxt = out_valid_r;
      out_angle_nxt = out_angle_r;
      out_total_nxt = out_total_r;
      out_custom_nxt = out_custom_r;
      out_vel_nxt   = out_vel_r;
      out_filt_nxt  = out_filt_r;
    end

    alpha_sat = (alpha_r > autv_pkg::ALPHA_ONE) ? autv_pkg::ALPHA_ONE : alpha_r;
    vel_sat   = autv_pkg::sat_vel(prod);
    acc_sum   = AW'(acc_r) + AW'(delta_r);
    want_ext  = OW'(in_custom_value);
    off_diff  = OW'(acc_r) - want_ext;
    // The arithmetic shift floors the Q16 product toward minus infinity.
    filt_sum  = PW'(filt_r) + (prod >>> autv_pkg::FRAC_BITS);

    mul_req.go = 1'b0;
    mul_req.a  = autv_pkg::MUL_A_W'(delta_r);
    mul_req.b  = {1'b0, gain_r};

    if (cfg_we) begin
      case (cfg_index)
        autv_pkg::CFG_FILTER_ALPHA:  alpha_nxt = cfg_data[autv_pkg::ALPHA_W-1:0];
        autv_pkg::CFG_VELOCITY_GAIN: gain_nxt  = cfg_data[autv_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_cmd == autv_pkg::CMD_SAMPLE) begin
            last_nxt  = in_raw_angle;
            delta_nxt = delta_w;
            st_nxt    = ST_MUL_VEL;
          end else begin
            off_nxt = off_diff[TOTAL_BITS-1:0];
            st_nxt  = ST_DONE;
          end
        end
      end
      ST_MUL_VEL: begin
        mul_req.go = 1'b1;
        acc_nxt    = acc_sum[TOTAL_BITS-1:0];
        st_nxt     = ST_VEL;
      end
      ST_VEL: begin
        vel_nxt  = vel_sat;
        diff_nxt = {vel_sat[VW-1], vel_sat} - {filt_r[VW-1], filt_r};
        st_nxt   = ST_MUL_FILT;
      end
      ST_MUL_FILT: begin
        mul_req.go = 1'b1;
        mul_req.a  = diff_r;
        mul_req.b  = autv_pkg::MUL_B_W'(alpha_sat);
        st_nxt     = ST_FILT;
      end
      ST_FILT: begin
        filt_nxt = autv_pkg::sat_vel(filt_sum);
        st_nxt   = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_angle_nxt  = last_r;
          out_total_nxt  = acc_r;
          out_custom_nxt = acc_r - off_r;
          out_vel_nxt    = vel_r;
          out_filt_nxt   = filt_r;
          st_nxt         = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      alpha_r     <= autv_pkg::ALPHA_ONE;
      gain_r      <= autv_pkg::GAIN_RST;
      last_r      <= '0;
      acc_r       <= '0;
      off_r       <= '0;
      vel_r       <= '0;
      filt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      alpha_r     <= alpha_nxt;
      gain_r      <= gain_nxt;
      last_r      <= last_nxt;
      acc_r       <= acc_nxt;
      off_r       <= off_nxt;
      vel_r       <= vel_nxt;
      filt_r      <= filt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    delta_r      <= delta_nxt;
    diff_r       <= diff_nxt;
    out_angle_r  <= out_angle_nxt;
    out_total_r  <= out_total_nxt;
    out_custom_r <= out_custom_nxt;
    out_vel_r    <= out_vel_nxt;
    out_filt_r   <= out_filt_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_angle_now       = out_angle_r;
  assign out_total_angle     = out_total_r;
  assign out_custom_total    = out_custom_r;
  assign out_velocity_raw    = out_vel_r;
  assign out_velocity_smooth = out_filt_r;

  `AUTV_ASSERT_NEXT(a_sample_starts_mul, in_accept && (in_cmd == autv_pkg::CMD_SAMPLE), st_r == ST_MUL_VEL, "sample beat did not start the multiply")
  `AUTV_ASSERT_NEXT(a_set_keeps_velocity, in_accept && (in_cmd == autv_pkg::CMD_SET_CUSTOM), $stable(vel_r) && $stable(filt_r) && (st_r == ST_DONE), "set command disturbed velocity state")
  `AUTV_ASSERT_NOW(a_angle_moves_on_sample, $past(rst_n) && !$stable(last_r), $past(in_accept) && ($past(in_cmd) == autv_pkg::CMD_SAMPLE), "last angle changed without a sample beat")

endmodule

>>> tb/angle_unwrap_velocity_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// angle_unwrap_velocity_tracker_tb
// Self-checking bench for the angle unwrap and velocity tracker. A short
// directed list of beats is followed by random rotation traces. Each phase
// uses its own filter and gain setting; in phases zero to five both
// channels idle at random. Each result beat is checked field by field against
// its typed directed row or a model of the unwrap, totals and velocity filter.
// ----------------------------------------------------------------------------
module angle_unwrap_velocity_tracker_tb;

  localparam int ANGLE_W      = 12;
  localparam int TOTAL_W      = 32;
  localparam int HALF_TURN    = 1 << (ANGLE_W - 1);
  localparam int FULL_TURN    = 1 << ANGLE_W;
  localparam int DIRECTED_N   = 19;
  localparam int PHASES       = 8;
  localparam int BEATS_PER_PH = 80;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SETTLE       = 20;
  localparam longint VEL_HI   = (64'sd1 <<< (autv_pkg::VEL_W - 1)) - 1;
  localparam longint VEL_LO   = -(64'sd1 <<< (autv_pkg::VEL_W - 1));
  localparam longint V_HALF   = 64'sd134217728;

  typedef struct packed {
    logic        [ANGLE_W-1:0]         angle_now;
    logic signed [TOTAL_W-1:0]         total_angle;
    logic signed [TOTAL_W-1:0]         custom_total;
    logic signed [autv_pkg::VEL_W-1:0] velocity_raw;
    logic signed [autv_pkg::VEL_W-1:0] velocity_smooth;
  } tracker_out_t;

  typedef struct packed {
    logic                          cmd;
    logic [ANGLE_W-1:0]            angle;
    logic [autv_pkg::CUSTOM_W-1:0] custom;
    logic                          typed;
    tracker_out_t                  want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_cmd = autv_pkg::CMD_SAMPLE;
  logic [ANGLE_W-1:0] in_raw_angle = '0;
  logic signed [autv_pkg::CUSTOM_W-1:0] in_custom_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ANGLE_W-1:0] out_angle_now;
  logic signed [TOTAL_W-1:0] out_total_angle;
  logic signed [TOTAL_W-1:0] out_custom_total;
  logic signed [autv_pkg::VEL_W-1:0] out_velocity_raw;
  logic signed [autv_pkg::VEL_W-1:0] out_velocity_smooth;
  logic cfg_we = 1'b0;
  logic cfg_index = autv_pkg::CFG_FILTER_ALPHA;
  logic [autv_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Tracker state as the bench sees it.
  logic [ANGLE_W-1:0] prev_angle = '0;
  logic [TOTAL_W-1:0] turn_total = '0;
  logic [TOTAL_W-1:0] user_offset = '0;
  longint vel_now = 0;
  longint vel_filt = 0;
  logic [autv_pkg::ALPHA_W-1:0] alpha_reg = autv_pkg::ALPHA_ONE;
  logic [autv_pkg::GAIN_W-1:0] gain_reg = autv_pkg::GAIN_RST;

  tracker_out_t pending_results[$];
  stim_row_t directed_rows[DIRECTED_N];
  logic [autv_pkg::CFG_DATA_W-1:0] phase_alpha[PHASES];
  logic [autv_pkg::CFG_DATA_W-1:0] phase_gain[PHASES];
  int fault_count = 0;
  int cycle_count = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;

  angle_unwrap_velocity_tracker #(
    .ANGLE_BITS(ANGLE_W),
    .TOTAL_BITS(TOTAL_W)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_raw_angle(in_raw_angle),
    .in_custom_value(in_custom_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_angle_now(out_angle_now),
    .out_total_angle(out_total_angle),
    .out_custom_total(out_custom_total),
    .out_velocity_raw(out_velocity_raw),
    .out_velocity_smooth(out_velocity_smooth),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_velocity(input longint v);
    if (v > VEL_HI) begin
      return VEL_HI;
    end else if (v < VEL_LO) begin
      return VEL_LO;
    end
    return v;
  endfunction

  function automatic tracker_out_t result_of(input int angle, input int total,
                                             input int custom, input longint vel,
                                             input longint filt);
    tracker_out_t r;
    r.angle_now       = angle[ANGLE_W-1:0];
    r.total_angle     = total;
    r.custom_total    = custom;
    r.velocity_raw    = vel[autv_pkg::VEL_W-1:0];
    r.velocity_smooth = filt[autv_pkg::VEL_W-1:0];
    return r;
  endfunction

  // Advances the bench state by one accepted beat and returns its result.
  function automatic tracker_out_t advance_tracker(input logic cmd,
                                                   input logic [ANGLE_W-1:0] angle,
                                                   input logic [autv_pkg::CUSTOM_W-1:0] custom);
    longint turn_step;
    longint alpha_eff;
    longint diff;
    if (cmd == autv_pkg::CMD_SAMPLE) begin
      turn_step = longint'(angle) - longint'(prev_angle);
      // A step of exactly half a turn either way is left alone.
      if (turn_step > HALF_TURN) begin
        turn_step = turn_step - FULL_TURN;
      end else if (turn_step < -HALF_TURN) begin
        turn_step = turn_step + FULL_TURN;
      end
      turn_total = turn_total + turn_step[TOTAL_W-1:0];
      prev_angle = angle;
      alpha_eff = (alpha_reg > autv_pkg::ALPHA_ONE) ? longint'(autv_pkg::ALPHA_ONE)
                                                    : longint'(alpha_reg);
      vel_now = clamp_velocity(turn_step * longint'(gain_reg));
      diff = vel_now - vel_filt;
      vel_filt = clamp_velocity(vel_filt + ((diff * alpha_eff) >>> 16));
    end else begin
      user_offset = turn_total - custom;
    end
    return result_of(int'(prev_angle), int'(turn_total), int'(turn_total - user_offset),
                     vel_now, vel_filt);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 10) begin
        $display("Mismatch on %s: expected %0h, got %0h", name, want, got);
      end
    end
  endfunction

  // Drives one beat, waits for it to be taken, records what it should produce
  // and then idles the sender as the current phase asks.
  task automatic issue_beat(input logic cmd, input logic [ANGLE_W-1:0] angle,
                            input logic [autv_pkg::CUSTOM_W-1:0] custom, input logic typed,
                            input tracker_out_t want);
    tracker_out_t predicted;
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_raw_angle    <= angle;
    in_custom_value <= custom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_tracker(cmd, angle, custom);
    pending_results.push_back(typed ? want : predicted);
    if ($urandom_range(99) < 2) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (pending_results.size() != 0) @(posedge clk);
    end else begin
      while ($urandom_range(99) < send_gap_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    if (in_valid) begin
      in_valid <= 1'b0;
    end
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(posedge clk) begin : result_check
    tracker_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("Unexpected result beat: angle %0h total %0h", out_angle_now,
                   out_total_angle);
        end
      end else begin
        want = pending_results.pop_front();
        check_field("angle_now", 64'(want.angle_now), 64'(out_angle_now));
        check_field("total_angle", 64'(want.total_angle), 64'(out_total_angle));
        check_field("custom_total", 64'(want.custom_total), 64'(out_custom_total));
        check_field("velocity_raw", 64'(want.velocity_raw), 64'(out_velocity_raw));
        check_field("velocity_smooth", 64'(want.velocity_smooth),
                    64'(out_velocity_smooth));
      end
    end
  end

  initial begin : stimulus
    tracker_out_t none;
    logic cmd;
    logic [ANGLE_W-1:0] angle;
    logic [autv_pkg::CUSTOM_W-1:0] custom;
    int pick;
    int target;

    none = '0;
    // Rows with a typed result run at the reset gain and alpha of one, where
    // the filter simply follows the raw velocity.
    directed_rows[0]  = '{autv_pkg::CMD_SAMPLE, 12'd0, 32'd0, 1'b1,
                          result_of(0, 0, 0, 0, 0)};
    directed_rows[1]  = '{autv_pkg::CMD_SAMPLE, 12'd2048, 32'd0, 1'b1,
                          result_of(2048, 2048, 2048, V_HALF, V_HALF)};
    directed_rows[2]  = '{autv_pkg::CMD_SAMPLE, 12'd0, 32'd0, 1'b1,
                          result_of(0, 0, 0, -V_HALF, -V_HALF)};
    directed_rows[3]  = '{autv_pkg::CMD_SAMPLE, 12'd4095, 32'd0, 1'b1,
                          result_of(4095, -1, -1, -65536, -65536)};
    directed_rows[4]  = '{autv_pkg::CMD_SAMPLE, 12'd0, 32'd0, 1'b1,
                          result_of(0, 0, 0, 65536, 65536)};
    directed_rows[5]  = '{autv_pkg::CMD_SET_CUSTOM, 12'd0, 32'd100, 1'b1,
                          result_of(0, 0, 100, 65536, 65536)};
    directed_rows[6]  = '{autv_pkg::CMD_SET_CUSTOM, 12'hFFF, 32'd0, 1'b1,
                          result_of(0, 0, 0, 65536, 65536)};
    directed_rows[7]  = '{autv_pkg::CMD_SET_CUSTOM, 12'd0, 32'h7FFF_FFFF, 1'b1,
                          result_of(0, 0, 32'sh7FFF_FFFF, 65536, 65536)};
    // The custom total wraps from its maximum to its minimum here.
    directed_rows[8]  = '{autv_pkg::CMD_SAMPLE, 12'd1, 32'd0, 1'b1,
                          result_of(1, 1, 32'sh8000_0000, 65536, 65536)};
    directed_rows[9]  = '{autv_pkg::CMD_SET_CUSTOM, 12'd1, 32'h8000_0000, 1'b1,
                          result_of(1, 1, 32'sh8000_0000, 65536, 65536)};
    directed_rows[10] = '{autv_pkg::CMD_SAMPLE, 12'd2049, 32'd0, 1'b0, none};
    directed_rows[11] = '{autv_pkg::CMD_SAMPLE, 12'd0, 32'hFFFF_FFFF, 1'b0, none};
    directed_rows[12] = '{autv_pkg::CMD_SAMPLE, 12'd2047, 32'd0, 1'b0, none};
    directed_rows[13] = '{autv_pkg::CMD_SAMPLE, 12'd4095, 32'd0, 1'b0, none};
    directed_rows[14] = '{autv_pkg::CMD_SAMPLE, 12'd2048, 32'd0, 1'b0, none};
    directed_rows[15] = '{autv_pkg::CMD_SAMPLE, 12'hAAA, 32'h5555_5555, 1'b0, none};
    directed_rows[16] = '{autv_pkg::CMD_SAMPLE, 12'h555, 32'hAAAA_AAAA, 1'b0, none};
    directed_rows[17] = '{autv_pkg::CMD_SET_CUSTOM, 12'hAAA, 32'h5555_5555, 1'b0, none};
    directed_rows[18] = '{autv_pkg::CMD_SET_CUSTOM, 12'h555, 32'hAAAA_AAAA, 1'b0, none};

    // Phase zero keeps the reset setting; the others cover the extremes,
    // an alpha above one that has to saturate, and random settings.
    phase_alpha[1] = 24'd0;        phase_gain[1] = 24'hFF_FFFF;
    phase_alpha[2] = 24'hFF_FFFF;  phase_gain[2] = 24'd1;
    phase_alpha[3] = 24'd1;        phase_gain[3] = 24'd0;
    phase_alpha[4] = 24'd32768;    phase_gain[4] = 24'd65536;
    phase_alpha[5] = 24'd65535;    phase_gain[5] = 24'hFF_FFFF;
    phase_alpha[6] = 24'd65536;    phase_gain[6] = 24'($urandom);
    phase_alpha[7] = 24'($urandom_range(131071, 0));
    phase_gain[7]  = 24'($urandom);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph < 3) begin
        send_gap_pct = 9;
        recv_stall_pct = 67;
      end else if (ph < 6) begin
        send_gap_pct = 67;
        recv_stall_pct = 9;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end

      if (ph == 0) begin
        for (int i = 0; i < DIRECTED_N; i++) begin
          issue_beat(directed_rows[i].cmd, directed_rows[i].angle,
                     directed_rows[i].custom, directed_rows[i].typed,
                     directed_rows[i].want);
        end
      end else begin
        drain_results();
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= autv_pkg::CFG_FILTER_ALPHA;
        cfg_data  <= phase_alpha[ph];
        @(posedge clk);
        alpha_reg = phase_alpha[ph][autv_pkg::ALPHA_W-1:0];
        cfg_index <= autv_pkg::CFG_VELOCITY_GAIN;
        cfg_data  <= phase_gain[ph];
        @(posedge clk);
        gain_reg = phase_gain[ph][autv_pkg::GAIN_W-1:0];
        cfg_we <= 1'b0;
      end

      // Mostly a shaft turning smoothly, with jumps near half a turn,
      // arbitrary angles and occasional set commands mixed in.
      for (int n = 0; n < BEATS_PER_PH; n++) begin
        custom = $urandom;
        angle  = ANGLE_W'($urandom);
        cmd    = autv_pkg::CMD_SAMPLE;
        pick   = $urandom_range(99);
        if (pick < 10) begin
          cmd = autv_pkg::CMD_SET_CUSTOM;
          case ($urandom_range(7))
            0: custom = 32'h7FFF_FFFF;
            1: custom = 32'h8000_0000;
            2: custom = 32'd0;
            default: ;
          endcase
        end else if (pick < 65) begin
          target = int'(prev_angle) + int'($urandom_range(128)) - 64;
          angle = target[ANGLE_W-1:0];
        end else if (pick < 80) begin
          target = HALF_TURN + int'($urandom_range(4)) - 2;
          if ($urandom_range(1) == 1) begin
            target = -target;
          end
          target = int'(prev_angle) + target;
          angle = target[ANGLE_W-1:0];
        end
        issue_beat(cmd, angle, custom, 1'b0, none);
      end
    end

    drain_results();
    repeat (SETTLE) @(posedge clk);
    if (fault_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
